/* hw/rtl/ssd_pkg.sv */
// shared types, codes, constants and character encoder of the segment display driver
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int TRY_LIMIT = 3;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_WRITE   = 2'd1;
  localparam logic [1:0] REQ_SETTING = 2'd2;
  localparam logic [1:0] REQ_INIT    = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_BIT   = 2'd2;
  localparam logic [1:0] PH_STOP  = 2'd3;

  localparam logic [1:0] STAGE_DATA_CMD = 2'd0;
  localparam logic [1:0] STAGE_BLANK    = 2'd1;
  localparam logic [1:0] STAGE_BRIGHT   = 2'd2;

  localparam logic [8:0] ACK_MARK    = 9'h100;
  localparam logic [7:0] CMD_ADDR    = 8'hc0;
  localparam logic [7:0] CMD_DISP_ON = 8'h88;
  localparam logic [7:0] CMD_DISP_OFF = 8'h80;
  localparam logic [7:0] CMD_DATA    = 8'h40;
  localparam logic [7:0] SEG_DASH    = 8'h40;
  localparam logic [7:0] SEG_BLANK   = 8'h00;
  localparam logic [2:0] BRIGHT_RST  = 3'd1;

  localparam logic [7:0] ALPHA_TAB [26] = '{
    8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h6f, 8'h74, 8'h06,
    8'h0e, 8'h00, 8'h38, 8'h00, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50,
    8'h6d, 8'h78, 8'h1c, 8'h00, 8'h00, 8'h76, 8'h6e, 8'h00
  };

  localparam logic [7:0] NUM_TAB [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic       dat_sampled;
    logic       enable;
    logic [7:0] char2;
    logic [7:0] char1;
    logic [7:0] char0;
    logic [1:0] req_type;
  } ssd_item_t;

  typedef struct packed {
    logic present;
    logic last_failed;
    logic accepted;
    logic busy_res;
    logic dat_level;
    logic clk_level;
  } ssd_res_t;

  function automatic logic [7:0] encode_char(input logic [7:0] c);
    logic [7:0] off;
    logic [7:0] seg;
    begin
      off = 8'h00;
      seg = SEG_BLANK;
      if (c >= 8'h30 && c <= 8'h39) begin
        off = c - 8'h30;
        seg = NUM_TAB[off[3:0]];
      end else if (c >= 8'h61 && c <= 8'h7a) begin
        off = c - 8'h61;
        seg = ALPHA_TAB[off[4:0]];
      end else if (c >= 8'h41 && c <= 8'h5a) begin
        off = c - 8'h41;
        seg = ALPHA_TAB[off[4:0]];
      end else if (c == 8'h2d) begin
        seg = SEG_DASH;
      end
      return seg;
    end
  endfunction

endpackage

/* hw/rtl/seven_segment_serial_display_driver.sv */
// top level of the serial segment display driver: handshake, settings register, result buffer
`timescale 1ns / 1ps

// serial master for a three-digit led driver on a two-wire open-drain bus
// in_* channel: one item per command or per bus time unit (tick); in_tuser
//   is the request kind (tick, write text, display setting, init)
// out_* channel: exactly one result per input item, in order, giving the
//   clock and data line levels and status after that item
// cfg_we / cfg_wdata: writes the 3-bit brightness used by display-on commands;
//   write only while no command is running
// a result is registered in the output entry, or in the skid entry while the output waits
// throughput: one item per cycle while in_tready is high; the whole update of the sequencer state
//   is one pass of logic between the state registers
// a two-entry result buffer lets one more item in while a result waits;
//   when both entries are full, in_tready drops until out_tready returns
// commands that arrive while a sequence runs are dropped (accepted = 0)
// reset: lines released high, sequencer idle, brightness 1, buffer empty
module seven_segment_serial_display_driver #(
  parameter int TRY_LIMIT = ssd_pkg::TRY_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char0, char1, char2, enable, dat_sampled, zero fill
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // clk_level, dat_level, busy_res, accepted, last_failed, present, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);
  import ssd_pkg::*;

  logic       in_fire;
  logic       out_fire;
  ssd_item_t  item;
  ssd_res_t   res;
  logic [2:0] bright_r;
  logic       ov_r, sv_r;
  ssd_res_t   od_r, sd_r;

  assign in_tready = !sv_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = ov_r && out_tready;

  assign item.req_type    = in_tuser;
  assign item.char0       = in_tdata[7:0];
  assign item.char1       = in_tdata[15:8];
  assign item.char2       = in_tdata[23:16];
  assign item.enable      = in_tdata[24];
  assign item.dat_sampled = in_tdata[25];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= BRIGHT_RST;
    end else if (cfg_we) begin
      bright_r <= cfg_wdata;
    end
  end

  ssd_seq #(
    .TRY_LIMIT (TRY_LIMIT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (in_fire),
    .item       (item),
    .brightness (bright_r),
    .res        (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (out_fire) begin
        sv_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (ov_r && !out_tready) begin
        sv_r <= 1'b1;
      end else begin
        ov_r <= 1'b1;
      end
    end else if (out_fire) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (out_fire) begin
        od_r <= sd_r;
      end
    end else if (in_fire) begin
      if (ov_r && !out_tready) begin
        sd_r <= res;
      end else begin
        od_r <= res;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, od_r};

endmodule

/* hw/rtl/ssd_seq.sv */
// command handling and tick-timed pin sequencer with frame retry
`timescale 1ns / 1ps

module ssd_seq #(
  parameter int TRY_LIMIT = ssd_pkg::TRY_LIMIT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  ssd_pkg::ssd_item_t item,
  input  logic [2:0]       brightness,
  output ssd_pkg::ssd_res_t  res
);
  import ssd_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] unit_r, unit_nxt;
  logic [8:0] shift_r, shift_nxt;
  logic [2:0] byte_r, byte_nxt;
  logic [1:0] try_r, try_nxt;
  logic [7:0] seg_r [3];
  logic [7:0] seg_nxt [3];
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic       fail_r, fail_nxt;
  logic       present_r, present_nxt;
  logic       lfail_r, lfail_nxt;
  logic       clk_r, clk_nxt;
  logic       dat_r, dat_nxt;
  logic [7:0] cmd_r, cmd_nxt;

  logic       is_write;
  logic       last_unit;
  logic       acc;
  logic [8:0] shifted;
  logic [7:0] fb_first;
  logic [7:0] fb_next;
  logic       retry_ok;

  assign is_write  = (kind_r == REQ_WRITE) || (kind_r == REQ_INIT && stage_r == STAGE_BLANK);
  assign last_unit = (unit_r == 3'd7);
  assign shifted   = shift_r >> 1;
  assign fb_first  = is_write ? CMD_ADDR : cmd_r;
  assign fb_next   = !is_write ? cmd_r :
                     (byte_r <= 3'd2) ? seg_r[byte_r[1:0]] : SEG_BLANK;
  assign retry_ok  = ({1'b0, try_r} + 3'd1) < 3'(TRY_LIMIT);

  always_comb begin
    phase_nxt   = phase_r;
    unit_nxt    = unit_r;
    shift_nxt   = shift_r;
    byte_nxt    = byte_r;
    try_nxt     = try_r;
    seg_nxt     = seg_r;
    kind_nxt    = kind_r;
    stage_nxt   = stage_r;
    fail_nxt    = fail_r;
    present_nxt = present_r;
    lfail_nxt   = lfail_r;
    clk_nxt     = clk_r;
    dat_nxt     = dat_r;
    cmd_nxt     = cmd_r;
    acc         = 1'b0;
    if (item_vld) begin
      if (item.req_type == REQ_TICK) begin
        if (phase_r != PH_IDLE) begin
          unit_nxt = unit_r + 3'd1;
          unique case (phase_r)
            PH_START, PH_STOP: begin
              if (unit_r == 3'd0) begin
                clk_nxt = 1'b0;
              end else if (unit_r == 3'd4) begin
                clk_nxt = 1'b1;
              end else if (unit_r == 3'd6) begin
                dat_nxt = (phase_r == PH_STOP);
              end
              if (last_unit) begin
                if (phase_r == PH_START) begin
                  byte_nxt  = 3'd0;
                  shift_nxt = {1'b0, fb_first} | ACK_MARK;
                  phase_nxt = PH_BIT;
                end else if (fail_r && retry_ok) begin
                  try_nxt   = try_r + 2'd1;
                  fail_nxt  = 1'b0;
                  byte_nxt  = 3'd0;
                  phase_nxt = PH_START;
                end else begin
                  // frame finished
                  lfail_nxt = fail_r;
                  phase_nxt = PH_IDLE;
                  if (kind_r == REQ_INIT) begin
                    if (stage_r == STAGE_DATA_CMD) begin
                      if (fail_r) begin
                        present_nxt = 1'b0;
                      end else begin
                        present_nxt = 1'b1;
                        stage_nxt   = STAGE_BLANK;
                        try_nxt     = 2'd0;
                        fail_nxt    = 1'b0;
                        byte_nxt    = 3'd0;
                        unit_nxt    = 3'd0;
                        phase_nxt   = PH_START;
                      end
                    end else if (stage_r == STAGE_BLANK) begin
                      stage_nxt = STAGE_BRIGHT;
                      cmd_nxt   = CMD_DISP_ON + {5'd0, brightness};
                      try_nxt   = 2'd0;
                      fail_nxt  = 1'b0;
                      byte_nxt  = 3'd0;
                      unit_nxt  = 3'd0;
                      phase_nxt = PH_START;
                    end
                  end
                end
              end
            end
            PH_BIT: begin
              if (unit_r == 3'd0) begin
                clk_nxt = 1'b0;
              end else if (unit_r == 3'd2) begin
                dat_nxt = shift_r[0];
              end else if (unit_r == 3'd3) begin
                if (shift_r == 9'd1) begin
                  fail_nxt = item.dat_sampled;
                  dat_nxt  = 1'b0;
                end
              end else if (unit_r == 3'd4) begin
                clk_nxt = 1'b1;
              end
              if (last_unit) begin
                shift_nxt = shifted;
                if (shifted == 9'd0) begin
                  if (fail_r || !is_write || byte_r >= 3'd4) begin
                    phase_nxt = PH_STOP;
                  end else begin
                    byte_nxt  = byte_r + 3'd1;
                    shift_nxt = {1'b0, fb_next} | ACK_MARK;
                  end
                end
              end
            end
            default: begin
              unit_nxt = 3'd0;
            end
          endcase
        end
      end else if (phase_r == PH_IDLE) begin
        acc = 1'b1;
        unique case (item.req_type)
          REQ_WRITE: begin
            seg_nxt[0] = encode_char(item.char0);
            seg_nxt[1] = encode_char(item.char1);
            seg_nxt[2] = encode_char(item.char2);
            kind_nxt   = REQ_WRITE;
          end
          REQ_SETTING: begin
            cmd_nxt  = item.enable ? (CMD_DISP_ON + {5'd0, brightness}) : CMD_DISP_OFF;
            kind_nxt = REQ_SETTING;
          end
          default: begin
            clk_nxt    = 1'b1;
            dat_nxt    = 1'b1;
            seg_nxt[0] = SEG_BLANK;
            seg_nxt[1] = SEG_BLANK;
            seg_nxt[2] = SEG_BLANK;
            cmd_nxt    = CMD_DATA;
            stage_nxt  = STAGE_DATA_CMD;
            kind_nxt   = REQ_INIT;
          end
        endcase
        try_nxt   = 2'd0;
        fail_nxt  = 1'b0;
        byte_nxt  = 3'd0;
        unit_nxt  = 3'd0;
        phase_nxt = PH_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      unit_r    <= 3'd0;
      shift_r   <= 9'd0;
      byte_r    <= 3'd0;
      try_r     <= 2'd0;
      kind_r    <= REQ_TICK;
      stage_r   <= STAGE_DATA_CMD;
      fail_r    <= 1'b0;
      present_r <= 1'b0;
      lfail_r   <= 1'b0;
      clk_r     <= 1'b1;
      dat_r     <= 1'b1;
      cmd_r     <= 8'h00;
    end else begin
      phase_r   <= phase_nxt;
      unit_r    <= unit_nxt;
      shift_r   <= shift_nxt;
      byte_r    <= byte_nxt;
      try_r     <= try_nxt;
      kind_r    <= kind_nxt;
      stage_r   <= stage_nxt;
      fail_r    <= fail_nxt;
      present_r <= present_nxt;
      lfail_r   <= lfail_nxt;
      clk_r     <= clk_nxt;
      dat_r     <= dat_nxt;
      cmd_r     <= cmd_nxt;
    end
  end

  // segment bytes are always written before a frame reads them
  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign res.clk_level   = clk_nxt;
  assign res.dat_level   = dat_nxt;
  assign res.busy_res    = (phase_nxt != PH_IDLE);
  assign res.accepted    = acc;
  assign res.last_failed = lfail_nxt;
  assign res.present     = present_nxt;

endmodule

/* hw/rtl/ssd_chk.sv */
// port-level checks of the segment display driver and their binding
`timescale 1ns / 1ps

module ssd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("taken item produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result buffer");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2])
    else $error("accepted command not busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind seven_segment_serial_display_driver ssd_chk u_ssd_chk (.*);
